### rtl/core/rpss_pkg.sv
// Shared constants, types and tables for the residue pair similarity scorer.
// No dependencies.
`default_nettype none
package rpss_pkg;
	localparam int COORD_BITS_DEF = 20;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int COEF_W         = 56;
	localparam int OUT_W          = 32;
	localparam int CFG_IDX_W      = 2;
	localparam int QUEUE_DEPTH    = 4;
	localparam int MUL_CHUNK      = 14;
	localparam int COEF_CHUNKS    = (COEF_W + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int TAYLOR_N       = 16;
	localparam int RECIP_SHIFT    = 35;
	localparam int RECIP_W        = 36;

	localparam logic [33:0] LOG2E_Q32 = 34'h1_7154_7653;
	localparam logic [31:0] LN2_Q32   = 32'hB172_17F8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIST_COEFF = 2'd0,
		CFG_CONF_COEFF = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic empty;
		logic room2;
	} q_stat_t;

	// floor(2^35 / n)
	function automatic logic [RECIP_W-1:0] recip(input logic [4:0] n);
		logic [RECIP_W-1:0] m;
		case (n)
			5'd1:    m = 36'd34359738368;
			5'd2:    m = 36'd17179869184;
			5'd3:    m = 36'd11453246122;
			5'd4:    m = 36'd8589934592;
			5'd5:    m = 36'd6871947673;
			5'd6:    m = 36'd5726623061;
			5'd7:    m = 36'd4908534052;
			5'd8:    m = 36'd4294967296;
			5'd9:    m = 36'd3817748707;
			5'd10:   m = 36'd3435973836;
			5'd11:   m = 36'd3123612578;
			5'd12:   m = 36'd2863311530;
			5'd13:   m = 36'd2643056797;
			5'd14:   m = 36'd2454267026;
			5'd15:   m = 36'd2290649224;
			5'd16:   m = 36'd2147483648;
			default: m = 36'd34359738368;
		endcase
		return m;
	endfunction
endpackage
`default_nettype wire

### rtl/core/rpss_queue.sv
// Short register queue of score jobs between front and back end.
// Depends on rpss_pkg.
`default_nettype none
module rpss_queue
	import rpss_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] pop_data,
	output q_stat_t               q_stat
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign pop_data     = mem_q[rd_ptr_q];
	assign q_stat.empty = (count_q == '0);
	assign q_stat.room2 = (count_q <= CNT_W'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/core/rpss_front.sv
// Front end: takes residue pairs, tracks run state, issues score jobs.
// Depends on rpss_pkg.
`default_nettype none
module rpss_front
	import rpss_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [COORD_BITS-1:0] x_first,
	input  wire logic signed [COORD_BITS-1:0] y_first,
	input  wire logic signed [COORD_BITS-1:0] z_first,
	input  wire logic signed [COORD_BITS-1:0] x_second,
	input  wire logic signed [COORD_BITS-1:0] y_second,
	input  wire logic signed [COORD_BITS-1:0] z_second,
	input  wire logic                         run_start,
	input  wire logic                         run_end,
	input  q_stat_t                           q_stat,
	output logic                              push,
	output logic [9*(COORD_BITS+1)+2:0]       push_job
);
	localparam int MAG_W = COORD_BITS + 1;
	localparam int JOB_W = 9 * MAG_W + 3;

	logic [COORD_BITS-1:0] cf [3];
	logic [COORD_BITS-1:0] cs [3];
	logic [MAG_W-1:0]      sep [3];
	logic [MAG_W-1:0]      new_mag [3];
	logic [MAG_W-1:0]      cur_q [3];
	logic [MAG_W-1:0]      prev_q [3];
	logic                  pend_valid_q, pend_start_q, hold_q;
	logic [JOB_W-1:0]      hold_job_q, job1, job2;
	logic                  accept, has_pred;

	assign cf[0] = x_first;
	assign cf[1] = y_first;
	assign cf[2] = z_first;
	assign cs[0] = x_second;
	assign cs[1] = y_second;
	assign cs[2] = z_second;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sep[a]     = {cf[a][COORD_BITS-1], cf[a]} - {cs[a][COORD_BITS-1], cs[a]};
			new_mag[a] = sep[a][MAG_W-1] ? MAG_W'(-sep[a]) : sep[a];
		end
	end

	assign has_pred = pend_valid_q && !run_start;
	assign in_stall = hold_q || !q_stat.room2;
	assign accept   = in_valid && !in_stall;

	assign job1 = {!run_end, !run_start, !pend_start_q,
		cur_q[0], cur_q[1], cur_q[2], prev_q[0], prev_q[1], prev_q[2],
		new_mag[0], new_mag[1], new_mag[2]};
	assign job2 = {1'b1, 1'b0, has_pred,
		new_mag[0], new_mag[1], new_mag[2], cur_q[0], cur_q[1], cur_q[2],
		new_mag[0], new_mag[1], new_mag[2]};

	assign push     = hold_q || (accept && (pend_valid_q || run_end));
	assign push_job = hold_q ? hold_job_q : (pend_valid_q ? job1 : job2);

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_job_q <= job2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				cur_q[a]  <= '0;
				prev_q[a] <= '0;
			end
			pend_valid_q <= 1'b0;
			pend_start_q <= 1'b0;
			hold_q       <= 1'b0;
		end else begin
			hold_q <= accept && pend_valid_q && run_end;
			if (accept) begin
				for (int a = 0; a < 3; a++) begin
					if (has_pred) begin
						prev_q[a] <= cur_q[a];
					end
					cur_q[a] <= new_mag[a];
				end
				pend_start_q <= !has_pred;
				pend_valid_q <= !run_end;
			end
		end
	end
endmodule
`default_nettype wire

### rtl/core/rpss_back.sv
// Back end: sequenced squares, coefficient scaling and fixed point exponential.
// Depends on rpss_pkg.
`default_nettype none
module rpss_back
	import rpss_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  q_stat_t                       q_stat,
	output logic                          pop,
	input  wire logic [9*(COORD_BITS+1)+2:0] pop_job,
	input  wire logic signed [COEF_W-1:0] dist_coeff,
	input  wire logic signed [COEF_W-1:0] conf_coeff,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [OUT_W-1:0]              prob,
	output logic signed [OUT_W-1:0]       dist_term,
	output logic signed [OUT_W-1:0]       conf_term,
	output logic                          last_result
);
	localparam int MAG_W   = COORD_BITS + 1;
	localparam int JOB_W   = 9 * MAG_W + 3;
	localparam int SQ_W    = 2 * MAG_W + 1;
	localparam int PW      = SQ_W + COEF_W;
	localparam int SH      = 48 - FRAC_BITS;
	localparam int XW      = FRAC_BITS + 7;
	localparam int YW      = XW + 35;
	localparam int FS      = FRAC_BITS + 32;
	localparam int IPW     = YW - FS;
	localparam int SUM_W   = 35;
	localparam int TERM_W  = 33;
	localparam int CHK_W   = (COEF_CHUNKS > 1) ? $clog2(COEF_CHUNKS) : 1;
	localparam logic signed [32:0] X_LIM = 33'(64'd32 << FRAC_BITS);

	typedef enum logic [3:0] {
		S_IDLE, S_SQ, S_MUL, S_TERM, S_EXP, S_RED, S_TMUL, S_TDIV, S_TFIX, S_DONE
	} state_t;

	state_t                    state_q;
	logic [JOB_W-1:0]          job_q;
	logic [1:0]                part_q, ax_q;
	logic [SQ_W-1:0]           dsq_q, csq_q;
	logic                      sel_q;
	logic [CHK_W-1:0]          chunk_q;
	logic [PW-1:0]             prod_q;
	logic signed [OUT_W-1:0]   dterm_q, cterm_q;
	logic signed [IPW-1:0]     ip_q;
	logic [31:0]               f_q, r_q, v_q, q0_q;
	logic [TERM_W-1:0]         term_q;
	logic [SUM_W-1:0]          sum_q;
	logic [4:0]                n_q;
	logic                      out_valid_q, last_q;
	logic [OUT_W-1:0]          prob_q;
	logic signed [OUT_W-1:0]   dt_out_q, ct_out_q;

	logic [MAG_W-1:0]          cur [3];
	logic [MAG_W-1:0]          pred [3];
	logic [MAG_W-1:0]          nxt [3];
	logic                      has_pred, has_next, job_last;
	logic [MAG_W-1:0]          op, cur_a, oth_a;
	logic [2*MAG_W-1:0]        sq;
	logic [COEF_W-1:0]         cm_mag;
	logic signed [COEF_W-1:0]  cm_sel;
	logic [SQ_W-1:0]           sq_sel;
	logic [MUL_CHUNK-1:0]      chunk;
	logic [SQ_W+MUL_CHUNK-1:0] pp;
	logic [PW:0]               rnd, mag_t;
	logic                      big;
	logic signed [OUT_W-1:0]   term_v;
	logic signed [32:0]        xs, xcl;
	logic signed [XW-1:0]      xc;
	logic signed [YW-1:0]      y;
	logic [63:0]               rp;
	logic [TERM_W+31:0]        tp;
	logic [31+RECIP_W:0]       dp;
	logic [36:0]               rem;
	logic [31:0]               nt;
	logic                      sat_hi, zero_res;
	logic signed [IPW-1:0]     rs;
	logic [5:0]                rsh;
	logic [35:0]               half, res36;
	logic [OUT_W-1:0]          prob_v;
	logic                      out_free;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			nxt[a]  = job_q[(2 - a) * MAG_W +: MAG_W];
			pred[a] = job_q[(5 - a) * MAG_W +: MAG_W];
			cur[a]  = job_q[(8 - a) * MAG_W +: MAG_W];
		end
	end
	assign has_pred = job_q[9 * MAG_W];
	assign has_next = job_q[9 * MAG_W + 1];
	assign job_last = job_q[9 * MAG_W + 2];

	// square sequencing
	always_comb begin
		cur_a = cur[ax_q];
		oth_a = (part_q == 2'd1) ? pred[ax_q] : nxt[ax_q];
		case (part_q)
			2'd0:    op = cur_a;
			2'd1:    op = has_pred ? ((cur_a >= oth_a) ? cur_a - oth_a : oth_a - cur_a) : '0;
			2'd2:    op = has_next ? ((cur_a >= oth_a) ? cur_a - oth_a : oth_a - cur_a) : '0;
			default: op = '0;
		endcase
		sq = op * op;
	end

	// coefficient scaling
	always_comb begin
		cm_sel = sel_q ? conf_coeff : dist_coeff;
		cm_mag = cm_sel[COEF_W-1] ? COEF_W'(-cm_sel) : cm_sel;
		sq_sel = sel_q ? csq_q : dsq_q;
		chunk  = MUL_CHUNK'(cm_mag >> (MUL_CHUNK * chunk_q));
		pp     = sq_sel * chunk;
		rnd    = {1'b0, prod_q} + ((PW + 1)'(1) << (SH - 1));
		mag_t  = rnd >> SH;
		big    = |mag_t[PW:31];
		if (cm_sel[COEF_W-1]) begin
			term_v = big ? 32'sh8000_0000 : -$signed(mag_t[31:0]);
		end else begin
			term_v = big ? 32'sh7FFF_FFFF : $signed(mag_t[31:0]);
		end
	end

	// exponent
	always_comb begin
		xs = {dterm_q[OUT_W-1], dterm_q} + {cterm_q[OUT_W-1], cterm_q};
		if (xs > X_LIM) begin
			xcl = X_LIM;
		end else if (xs < -X_LIM) begin
			xcl = -X_LIM;
		end else begin
			xcl = xs;
		end
		xc  = XW'(xcl);
		y   = xc * $signed({1'b0, LOG2E_Q32});
		rp  = f_q * LN2_Q32;
		tp  = term_q * r_q;
		dp  = v_q * recip(n_q);
		rem = {5'b0, v_q} - 37'(q0_q * n_q);
		nt  = (rem >= 37'(n_q)) ? q0_q + 1'b1 : q0_q;
	end

	always_comb begin
		sat_hi   = ip_q >= $signed(IPW'(32 - FRAC_BITS));
		rs       = $signed(IPW'(32 - FRAC_BITS)) - ip_q;
		zero_res = rs >= $signed(IPW'(35));
		rsh      = rs[5:0];
		half     = 36'(1) << (rsh - 1'b1);
		res36    = ({1'b0, sum_q} + half) >> rsh;
		if (sat_hi) begin
			prob_v = '1;
		end else if (zero_res) begin
			prob_v = '0;
		end else if (|res36[35:32]) begin
			prob_v = '1;
		end else begin
			prob_v = res36[31:0];
		end
	end

	assign out_free    = !out_valid_q || !out_stall;
	assign pop         = (state_q == S_IDLE) && !q_stat.empty;
	assign out_valid   = out_valid_q;
	assign prob        = prob_q;
	assign dist_term   = dt_out_q;
	assign conf_term   = ct_out_q;
	assign last_result = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			part_q      <= '0;
			ax_q        <= '0;
			sel_q       <= 1'b0;
			chunk_q     <= '0;
			n_q         <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						job_q   <= pop_job;
						part_q  <= '0;
						ax_q    <= '0;
						dsq_q   <= '0;
						csq_q   <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (part_q == 2'd0) begin
						dsq_q <= dsq_q + SQ_W'(sq);
					end else begin
						csq_q <= csq_q + SQ_W'(sq);
					end
					if (ax_q == 2'd2) begin
						ax_q   <= '0;
						part_q <= part_q + 1'b1;
						if (part_q == 2'd2) begin
							sel_q   <= 1'b0;
							chunk_q <= '0;
							prod_q  <= '0;
							state_q <= S_MUL;
						end
					end else begin
						ax_q <= ax_q + 1'b1;
					end
				end
				S_MUL: begin
					prod_q <= prod_q + (PW'(pp) << (MUL_CHUNK * chunk_q));
					if (chunk_q == CHK_W'(COEF_CHUNKS - 1)) begin
						state_q <= S_TERM;
					end else begin
						chunk_q <= chunk_q + 1'b1;
					end
				end
				S_TERM: begin
					if (!sel_q) begin
						dterm_q <= term_v;
						sel_q   <= 1'b1;
						chunk_q <= '0;
						prod_q  <= '0;
						state_q <= S_MUL;
					end else begin
						cterm_q <= term_v;
						state_q <= S_EXP;
					end
				end
				S_EXP: begin
					ip_q    <= y[YW-1:FS];
					f_q     <= y[FS-1:FRAC_BITS];
					state_q <= S_RED;
				end
				S_RED: begin
					r_q     <= rp[63:32];
					term_q  <= TERM_W'(64'h1_0000_0000);
					sum_q   <= SUM_W'(64'h1_0000_0000);
					n_q     <= 5'd1;
					state_q <= S_TMUL;
				end
				S_TMUL: begin
					v_q     <= tp[63:32];
					state_q <= S_TDIV;
				end
				S_TDIV: begin
					q0_q    <= dp[RECIP_SHIFT+31:RECIP_SHIFT];
					state_q <= S_TFIX;
				end
				S_TFIX: begin
					term_q <= TERM_W'(nt);
					sum_q  <= sum_q + SUM_W'(nt);
					if (n_q == 5'(TAYLOR_N)) begin
						state_q <= S_DONE;
					end else begin
						n_q     <= n_q + 1'b1;
						state_q <= S_TMUL;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						prob_q      <= prob_v;
						dt_out_q    <= dterm_q;
						ct_out_q    <= cterm_q;
						last_q      <= job_last;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/core/residue_pair_similarity_score.sv
// Top level of the residue pair similarity scorer: config registers, front end,
// job queue and back end. Depends on rpss_pkg, rpss_front, rpss_queue, rpss_back.
//
// Each residue pair yields its score once its successor or the run end is known,
// so an item gives zero, one or two results. For each result the back end runs 9
// squaring steps, two 4-step coefficient products and a 16-term Taylor series, each
// term a multiply, a divide and a quotient fix step; it pops no new job until
// that result has left S_DONE. The front end accepts a new item whenever the
// four-entry job queue has room for two jobs, except in the cycle after an item that
// yields two jobs, and the back end keeps working while a finished result waits on
// out_stall.
`default_nettype none
module residue_pair_similarity_score
	import rpss_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [COEF_W-1:0]            cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [COORD_BITS-1:0] x_first,
	input  wire logic signed [COORD_BITS-1:0] y_first,
	input  wire logic signed [COORD_BITS-1:0] z_first,
	input  wire logic signed [COORD_BITS-1:0] x_second,
	input  wire logic signed [COORD_BITS-1:0] y_second,
	input  wire logic signed [COORD_BITS-1:0] z_second,
	input  wire logic                         run_start,
	input  wire logic                         run_end,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [OUT_W-1:0]                  prob,
	output logic signed [OUT_W-1:0]           dist_term,
	output logic signed [OUT_W-1:0]           conf_term,
	output logic                              last_result
);
	localparam int JOB_W = 9 * (COORD_BITS + 1) + 3;

	logic signed [COEF_W-1:0] dist_coeff_q, conf_coeff_q;
	q_stat_t                  q_stat;
	logic                     push, pop;
	logic [JOB_W-1:0]         push_job, pop_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_coeff_q <= '0;
			conf_coeff_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_DIST_COEFF: dist_coeff_q <= cfg_data;
				CFG_CONF_COEFF: conf_coeff_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rpss_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.x_first  (x_first),
		.y_first  (y_first),
		.z_first  (z_first),
		.x_second (x_second),
		.y_second (y_second),
		.z_second (z_second),
		.run_start(run_start),
		.run_end  (run_end),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	rpss_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_job),
		.pop      (pop),
		.pop_data (pop_job),
		.q_stat   (q_stat)
	);

	rpss_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.pop        (pop),
		.pop_job    (pop_job),
		.dist_coeff (dist_coeff_q),
		.conf_coeff (conf_coeff_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.prob       (prob),
		.dist_term  (dist_term),
		.conf_term  (conf_term),
		.last_result(last_result)
	);
endmodule
`default_nettype wire

### rtl/core/rpss_checker.sv
// Port level checks of the residue pair similarity scorer, bound to the top level.
// Depends on rpss_pkg.
`default_nettype none
module rpss_checker
	import rpss_pkg::*;
#(
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_stall,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic [OUT_W-1:0]             prob,
	input wire logic signed [OUT_W-1:0]      dist_term,
	input wire logic signed [OUT_W-1:0]      conf_term,
	input wire logic                         last_result
);
	logic       in_beat, out_beat, expect_last_q;
	logic [7:0] owed_q;

	assign in_beat  = in_valid && !in_stall;
	assign out_beat = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q        <= '0;
			expect_last_q <= 1'b0;
		end else begin
			owed_q <= owed_q + 8'(in_beat) - 8'(out_beat);
			if (out_beat) begin
				expect_last_q <= !last_result;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(prob) && $stable(last_result))
		else $error("result changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> owed_q != 8'd0)
		else $error("result beat without a residue to score");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && expect_last_q |-> last_result)
		else $error("second result of an item not marked last");

	a_unit_exp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ({dist_term[OUT_W-1], dist_term} + {conf_term[OUT_W-1], conf_term})
			== 33'd0 |-> prob == (OUT_W'(1) << FRAC_BITS))
		else $error("exp of zero is not one");
endmodule

bind residue_pair_similarity_score rpss_checker #(
	.FRAC_BITS (FRAC_BITS)
) u_rpss_checker (.*);
`default_nettype wire
